// File: rtl/core/latent_factor_rating_predictor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rating predictor
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LATENT_FACTOR_RATING_PREDICTOR_UNIT_DEFINES_SVH
`define LATENT_FACTOR_RATING_PREDICTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lfrp_pkg.sv
// ----------------------------------------------------------------------------
// Rating predictor package
// Field widths, command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrp_pkg;

  localparam int ACT_W    = 3;
  localparam int ID_W     = 11;
  localparam int IDX_W    = 5;
  localparam int VAL_W    = 16;
  localparam int RATING_W = 15;
  localparam int CFG_IDX_W = 1;

  // Ratings are unsigned Q3.12; the clamp window is 1.0 to 5.0.
  localparam logic [RATING_W-1:0] RATING_MIN           = 15'd4096;
  localparam logic [RATING_W-1:0] RATING_MAX           = 15'd20480;
  localparam logic [RATING_W-1:0] RATING_AVERAGE_RESET = 15'd14746;

  typedef enum logic [ACT_W-1:0] {
    ACT_USER_FACTOR  = 3'd0,
    ACT_MOVIE_FACTOR = 3'd1,
    ACT_USER_BIAS    = 3'd2,
    ACT_MOVIE_BIAS   = 3'd3,
    ACT_PREDICT      = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATING_AVERAGE = 1'b0,
    REG_BIAS_ENABLE    = 1'b1
  } cfg_reg_t;

  // Tags that travel with each word pair read from the tables.
  typedef struct packed {
    logic valid;
    logic first;
    logic bias;
  } term_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/lfrp_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lfrp_mac.sv
// ----------------------------------------------------------------------------
// Rating predictor multiply-accumulate
// Multiplies factor pairs, adds the bias term, and clamps the total.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrp_mac import lfrp_pkg::*; #(
  parameter int NUM_FACTORS = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire term_ctl_t                  term_ctl,
  input  wire logic signed [VAL_W-1:0]    user_word,
  input  wire logic signed [VAL_W-1:0]    movie_word,
  input  wire logic        [RATING_W-1:0] rating_average,
  input  wire logic                       bias_enable,
  output logic                            done,
  output logic             [RATING_W-1:0] predicted_rating
);

  localparam int TERM_W = 2 * VAL_W;
  localparam int BIAS_W = VAL_W + 2;
  localparam int ACC_W  = TERM_W + 1 + $clog2(NUM_FACTORS + 1);
  localparam logic signed [ACC_W-1:0] ACC_LOW  = ACC_W'(longint'(RATING_MIN) << 12);
  localparam logic signed [ACC_W-1:0] ACC_HIGH = ACC_W'(longint'(RATING_MAX) << 12);

  logic signed [TERM_W-1:0]   product;
  logic signed [BIAS_W-1:0]   bias_sum;
  logic signed [BIAS_W+11:0]  bias_scaled;
  logic signed [TERM_W-1:0]   term;
  logic signed [TERM_W-1:0]   term_next;
  term_ctl_t                  s1_ctl;
  logic signed [ACC_W-1:0]    acc;
  logic                       acc_done;

  assign product     = user_word * movie_word;
  assign bias_sum    = $signed({3'b000, rating_average}) + BIAS_W'(user_word)
                     + BIAS_W'(movie_word);
  assign bias_scaled = {bias_sum, 12'b0};

  // The bias word pair arrives last; with bias off it contributes nothing.
  always_comb begin
    if (term_ctl.bias) begin
      term_next = bias_enable ? TERM_W'(bias_scaled) : '0;
    end else begin
      term_next = product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl   <= '0;
      acc_done <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_ctl   <= term_ctl;
      acc_done <= s1_ctl.valid && s1_ctl.bias;
      done     <= acc_done;
    end
  end

  always_ff @(posedge clk) begin
    term <= term_next;
    if (s1_ctl.valid) begin
      acc <= s1_ctl.first ? ACC_W'(term) : acc + ACC_W'(term);
    end
    if (acc_done) begin
      priority if (acc < ACC_LOW) begin
        predicted_rating <= RATING_MIN;
      end else if (acc > ACC_HIGH) begin
        predicted_rating <= RATING_MAX;
      end else begin
        predicted_rating <= acc[RATING_W+11:12];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/latent_factor_rating_predictor_unit.sv
// ----------------------------------------------------------------------------
// Latent-factor rating predictor
// Biased dot product of a user factor row and a movie factor row, clamped.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | transfer when
//  ---------+------------------------------------------------+---------------------
//  command  | start, busy, action, user_id, movie_id,        | start && !busy
//           | factor_index, load_value                       |
//  result   | done, predicted_rating                         | done (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | cfg_valid && cfg_ready
//
// Loads write one table word at the transfer edge and never raise busy.
// A predict holds busy through NUM_FACTORS + 1 reads of one row from each
// table memory, one per cycle, then a four-stage drain through read, multiply,
// accumulate and clamp. done comes in the last busy cycle. Busy also blocks
// loads, so reads and writes never meet on one entry.
// Reset is synchronous; the tables are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module latent_factor_rating_predictor_unit import lfrp_pkg::*; #(
  parameter int NUM_USERS   = 1024,
  parameter int NUM_MOVIES  = 1024,
  parameter int NUM_FACTORS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ACT_W-1:0]     action,
  input  wire logic [ID_W-1:0]      user_id,
  input  wire logic [ID_W-1:0]      movie_id,
  input  wire logic [IDX_W-1:0]     factor_index,
  input  wire logic [VAL_W-1:0]     load_value,
  output logic                      done,
  output logic      [RATING_W-1:0]  predicted_rating,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATING_W-1:0]  cfg_data
);

  // Each row holds the factors and, in its last word, the bias.
  localparam int ROW_W   = NUM_FACTORS + 1;
  localparam int U_DEPTH = NUM_USERS * ROW_W;
  localparam int M_DEPTH = NUM_MOVIES * ROW_W;
  localparam int UAW     = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
  localparam int MAW     = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;
  localparam int CNT_W   = $clog2(ROW_W);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    cnt;
  logic [UAW-1:0]      u_base;
  logic [MAW-1:0]      m_base;
  logic [RATING_W-1:0] rating_average;
  logic                bias_enable;

  logic                accept;
  logic                user_ok;
  logic                movie_ok;
  logic                factor_ok;
  logic [31:0]         user_row;
  logic [31:0]         movie_row;
  logic [31:0]         word_off;
  logic                u_we;
  logic                m_we;
  logic                predict_go;
  logic                rd_en;
  logic [UAW-1:0]      u_raddr;
  logic [MAW-1:0]      m_raddr;
  logic [VAL_W-1:0]    u_rdata;
  logic [VAL_W-1:0]    m_rdata;
  term_ctl_t           issue_ctl;
  term_ctl_t           term_ctl;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign user_ok   = (user_id != '0) && (32'(user_id) <= 32'(NUM_USERS));
  assign movie_ok  = (movie_id != '0) && (32'(movie_id) <= 32'(NUM_MOVIES));
  assign factor_ok = 32'(factor_index) < 32'(NUM_FACTORS);

  assign user_row  = (32'(user_id) - 32'd1) * 32'(ROW_W);
  assign movie_row = (32'(movie_id) - 32'd1) * 32'(ROW_W);

  always_comb begin
    u_we       = 1'b0;
    m_we       = 1'b0;
    predict_go = 1'b0;
    word_off   = 32'(factor_index);
    unique case (action)
      ACT_USER_FACTOR:  u_we = accept && user_ok && factor_ok;
      ACT_MOVIE_FACTOR: m_we = accept && movie_ok && factor_ok;
      ACT_USER_BIAS: begin
        u_we     = accept && user_ok;
        word_off = 32'(NUM_FACTORS);
      end
      ACT_MOVIE_BIAS: begin
        m_we     = accept && movie_ok;
        word_off = 32'(NUM_FACTORS);
      end
      ACT_PREDICT:      predict_go = accept && user_ok && movie_ok;
      default: begin
      end
    endcase
  end

  // Read sequencer: one word of each row per cycle, bias word last.
  assign rd_en           = (state == S_READ);
  assign u_raddr         = u_base + UAW'(cnt);
  assign m_raddr         = m_base + MAW'(cnt);
  assign issue_ctl.valid = rd_en;
  assign issue_ctl.first = (cnt == '0);
  assign issue_ctl.bias  = (cnt == CNT_W'(NUM_FACTORS));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (predict_go) state_next = S_READ;
      S_READ:  if (issue_ctl.bias) state_next = S_DRAIN;
      S_DRAIN: if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      term_ctl       <= '0;
      rating_average <= RATING_AVERAGE_RESET;
      bias_enable    <= 1'b1;
    end else begin
      state    <= state_next;
      term_ctl <= issue_ctl;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RATING_AVERAGE: rating_average <= cfg_data;
          REG_BIAS_ENABLE:    bias_enable    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (predict_go) begin
      cnt    <= '0;
      u_base <= UAW'(user_row);
      m_base <= MAW'(movie_row);
    end else if (rd_en) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  lfrp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (U_DEPTH),
    .AW    (UAW)
  ) u_user_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (UAW'(user_row + word_off)),
    .wdata (load_value),
    .re    (rd_en),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  lfrp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (M_DEPTH),
    .AW    (MAW)
  ) u_movie_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (MAW'(movie_row + word_off)),
    .wdata (load_value),
    .re    (rd_en),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  lfrp_mac #(
    .NUM_FACTORS (NUM_FACTORS)
  ) u_mac (
    .clk              (clk),
    .rst              (rst),
    .term_ctl         (term_ctl),
    .user_word        ($signed(u_rdata)),
    .movie_word       ($signed(m_rdata)),
    .rating_average   (rating_average),
    .bias_enable      (bias_enable),
    .done             (done),
    .predicted_rating (predicted_rating)
  );

endmodule

`default_nettype wire

// File: rtl/core/lfrp_checker.sv
// ----------------------------------------------------------------------------
// Rating predictor port checker
// Watches the top-level ports for command and result ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latent_factor_rating_predictor_unit_defines.svh"

module lfrp_checker import lfrp_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [ACT_W-1:0]    action,
  input wire logic                done,
  input wire logic [RATING_W-1:0] predicted_rating
);

  // A result only ever comes out of a running prediction.
  `LFRP_ASSERT_IMPLY(a_done_while_busy, clk, rst, done, busy, "result strobe while idle")

  `LFRP_ASSERT_IMPLY(a_rating_range, clk, rst, done,
    (predicted_rating >= RATING_MIN) && (predicted_rating <= RATING_MAX),
    "prediction outside the clamp window")

  // Loads and unknown commands finish at their transfer.
  `LFRP_ASSERT_NEXT(a_load_no_busy, clk, rst, start && !busy && (action != ACT_PREDICT),
    !busy, "non-predict command raised busy")

  `LFRP_ASSERT_NEXT(a_idle_after_done, clk, rst, done, !busy, "still busy after result")

endmodule

bind latent_factor_rating_predictor_unit lfrp_checker u_lfrp_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .action           (action),
  .done             (done),
  .predicted_rating (predicted_rating)
);

`default_nettype wire

// File: test/lfrp_rating_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rating predictor checker
// Watches the command, result and register channels, keeps a shadow copy of
// the factor and bias tables and the two registers, works out the rating
// that each accepted predict command must produce, and compares every
// result strobe with the oldest rating still owed.
// ----------------------------------------------------------------------------
module lfrp_rating_checker import lfrp_pkg::*; #(
  parameter int NUM_USERS   = 1024,
  parameter int NUM_MOVIES  = 1024,
  parameter int NUM_FACTORS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [ACT_W-1:0]     action,
  input  logic [ID_W-1:0]      user_id,
  input  logic [ID_W-1:0]      movie_id,
  input  logic [IDX_W-1:0]     factor_index,
  input  logic [VAL_W-1:0]     load_value,
  input  logic                 done,
  input  logic [RATING_W-1:0]  predicted_rating,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATING_W-1:0]  cfg_data,
  output int                   error_count,
  output int                   ratings_outstanding
);

  localparam longint ONE_Q24 = longint'(1) << 24;

  logic signed [VAL_W-1:0] user_factor [0:NUM_USERS*NUM_FACTORS-1];
  logic signed [VAL_W-1:0] movie_factor [0:NUM_MOVIES*NUM_FACTORS-1];
  logic signed [VAL_W-1:0] viewer_bias [0:NUM_USERS-1];
  logic signed [VAL_W-1:0] title_bias [0:NUM_MOVIES-1];
  logic [RATING_W-1:0]     average;
  logic                    bias_on;

  logic [RATING_W-1:0] owed_ratings [$];
  logic [RATING_W-1:0] oldest;
  int                  errors = 0;
  int                  owed = 0;
  int                  uid, mid, fidx;

  assign error_count = errors;
  assign ratings_outstanding = owed;

  function automatic bit id_in_range(int id, int count);
    return id >= 1 && id <= count;
  endfunction

  // Exact Q8.24 dot product plus biases, clamped to 1.0..5.0, back to Q3.12.
  function automatic logic [RATING_W-1:0] expected_rating(int u, int m);
    longint acc;
    int     ubase, mbase;
    ubase = (u - 1) * NUM_FACTORS;
    mbase = (m - 1) * NUM_FACTORS;
    acc = 0;
    for (int f = 0; f < NUM_FACTORS; f++) begin
      acc += longint'(user_factor[ubase + f]) * longint'(movie_factor[mbase + f]);
    end
    if (bias_on) begin
      acc += (longint'(average) + longint'(viewer_bias[u - 1]) +
              longint'(title_bias[m - 1])) * 4096;
    end
    if (acc < ONE_Q24) begin
      return RATING_MIN;
    end else if (acc > 5 * ONE_Q24) begin
      return RATING_MAX;
    end
    return acc[RATING_W+11:12];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      average = RATING_AVERAGE_RESET;
      bias_on = 1'b1;
      owed_ratings.delete();
    end else begin
      if (done) begin
        if (owed_ratings.size() == 0) begin
          $error("predicted_rating: expected none, actual %0d", predicted_rating);
          errors++;
        end else begin
          oldest = owed_ratings.pop_front();
          if (predicted_rating !== oldest) begin
            $error("predicted_rating: expected %0d, actual %0d", oldest, predicted_rating);
            errors++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATING_AVERAGE: average = cfg_data;
          REG_BIAS_ENABLE:    bias_on = cfg_data[0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        uid  = user_id;
        mid  = movie_id;
        fidx = factor_index;
        case (action)
          ACT_USER_FACTOR: begin
            if (id_in_range(uid, NUM_USERS) && fidx < NUM_FACTORS) begin
              user_factor[(uid - 1) * NUM_FACTORS + fidx] = load_value;
            end
          end
          ACT_MOVIE_FACTOR: begin
            if (id_in_range(mid, NUM_MOVIES) && fidx < NUM_FACTORS) begin
              movie_factor[(mid - 1) * NUM_FACTORS + fidx] = load_value;
            end
          end
          ACT_USER_BIAS: begin
            if (id_in_range(uid, NUM_USERS)) begin
              viewer_bias[uid - 1] = load_value;
            end
          end
          ACT_MOVIE_BIAS: begin
            if (id_in_range(mid, NUM_MOVIES)) begin
              title_bias[mid - 1] = load_value;
            end
          end
          ACT_PREDICT: begin
            if (id_in_range(uid, NUM_USERS) && id_in_range(mid, NUM_MOVIES)) begin
              owed_ratings.push_back(expected_rating(uid, mid));
            end
          end
          default: ;
        endcase
      end
    end
    owed <= owed_ratings.size();
  end

endmodule

// File: test/tb_latent_factor_rating_predictor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rating predictor testbench
// Loads a set of user and movie rows, runs directed predicts at the clamp
// limits and with ignored commands, then random phases of loads, predicts
// and malformed commands under several register settings, with random idle
// gaps. The checker beside the block does all result comparison.
// ----------------------------------------------------------------------------
module tb_latent_factor_rating_predictor_unit;
  import lfrp_pkg::*;

  localparam int NUM_USERS       = 1024;
  localparam int NUM_MOVIES      = 1024;
  localparam int NUM_FACTORS     = 20;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int SETTLE_CYCLES   = NUM_FACTORS + 10;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ID_MAX          = 2**ID_W - 1;
  localparam int IDX_MAX         = 2**IDX_W - 1;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MAX       = 16'h7FFF;
  localparam logic [VAL_W-1:0] VAL_MIN       = 16'h8000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [ACT_W-1:0]     action;
  logic [ID_W-1:0]      user_id;
  logic [ID_W-1:0]      movie_id;
  logic [IDX_W-1:0]     factor_index;
  logic [VAL_W-1:0]     load_value;
  logic                 done;
  logic [RATING_W-1:0]  predicted_rating;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATING_W-1:0]  cfg_data;

  int fail_count;
  int ratings_owed;
  int cycle_count = 0;
  bit calm;

  // Ids whose whole row and bias are loaded, so a predict never reads an
  // unloaded entry.
  int                   loaded_users [$];
  int                   loaded_movies [$];

  latent_factor_rating_predictor_unit #(
    .NUM_USERS  (NUM_USERS),
    .NUM_MOVIES (NUM_MOVIES),
    .NUM_FACTORS(NUM_FACTORS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .user_id         (user_id),
    .movie_id        (movie_id),
    .factor_index    (factor_index),
    .load_value      (load_value),
    .done            (done),
    .predicted_rating(predicted_rating),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lfrp_rating_checker #(
    .NUM_USERS  (NUM_USERS),
    .NUM_MOVIES (NUM_MOVIES),
    .NUM_FACTORS(NUM_FACTORS)
  ) u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .action             (action),
    .user_id            (user_id),
    .movie_id           (movie_id),
    .factor_index       (factor_index),
    .load_value         (load_value),
    .done               (done),
    .predicted_rating   (predicted_rating),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .error_count        (fail_count),
    .ratings_outstanding(ratings_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, ID_MAX));
  endfunction

  function automatic logic [ID_W-1:0] bad_id();
    if ($urandom_range(0, 1) == 0) begin
      return '0;
    end
    return ID_W'($urandom_range(NUM_USERS + 1, ID_MAX));
  endfunction

  // Mostly small values so that sums land inside the clamp window.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3, 4:    return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, 1536)) - VAL_W'(768);
    endcase
  endfunction

  function automatic int idle_cycles();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  task automatic issue(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] u,
                       input logic [ID_W-1:0] m, input logic [IDX_W-1:0] k,
                       input logic [VAL_W-1:0] v);
    int gap;
    start        <= 1'b1;
    action       <= act;
    user_id      <= u;
    movie_id     <= m;
    factor_index <= k;
    load_value   <= v;
    do @(posedge clk); while (busy);
    gap = idle_cycles();
    if (gap > 0) begin
      // Junk on the fields while start is low must be ignored.
      start        <= 1'b0;
      action       <= ACT_W'($urandom);
      user_id      <= any_id();
      movie_id     <= any_id();
      factor_index <= IDX_W'($urandom);
      load_value   <= VAL_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic predict(input logic [ID_W-1:0] u, input logic [ID_W-1:0] m);
    issue(ACT_PREDICT, u, m, IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic load_row(input bit is_user, input int id, input bit fixed,
                          input logic [VAL_W-1:0] fill);
    for (int k = 0; k < NUM_FACTORS; k++) begin
      if (is_user) begin
        issue(ACT_USER_FACTOR, ID_W'(id), any_id(), IDX_W'(k), fixed ? fill : pick_value());
      end else begin
        issue(ACT_MOVIE_FACTOR, any_id(), ID_W'(id), IDX_W'(k), fixed ? fill : pick_value());
      end
    end
    if (is_user) begin
      issue(ACT_USER_BIAS, ID_W'(id), any_id(), IDX_W'($urandom), fixed ? fill : pick_value());
      loaded_users.push_back(id);
    end else begin
      issue(ACT_MOVIE_BIAS, any_id(), ID_W'(id), IDX_W'($urandom), fixed ? fill : pick_value());
      loaded_movies.push_back(id);
    end
  endtask

  // Waits until every owed rating has come back and the block has settled.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (ratings_owed != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [RATING_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic random_item();
    int          r;
    logic [ID_W-1:0] u, m;
    r = $urandom_range(0, 99);
    u = ID_W'(loaded_users[$urandom_range(0, loaded_users.size() - 1)]);
    m = ID_W'(loaded_movies[$urandom_range(0, loaded_movies.size() - 1)]);
    if (r < 45) begin
      predict(u, m);
    end else if (r < 70) begin
      issue(ACT_W'($urandom_range(ACT_USER_FACTOR, ACT_MOVIE_BIAS)), u, m,
            IDX_W'($urandom_range(0, NUM_FACTORS - 1)), pick_value());
    end else if (r < 80) begin
      issue(ACT_W'($urandom_range(ACT_USER_FACTOR, ACT_MOVIE_BIAS)),
            ID_W'($urandom_range(1, NUM_USERS)), ID_W'($urandom_range(1, NUM_MOVIES)),
            IDX_W'($urandom_range(0, NUM_FACTORS - 1)), pick_value());
    end else begin
      case ($urandom_range(0, 3))
        0: issue(ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), any_id(), any_id(),
                 IDX_W'($urandom), VAL_W'($urandom));
        1: issue($urandom_range(0, 1) ? ACT_USER_FACTOR : ACT_MOVIE_FACTOR,
                 ID_W'($urandom_range(1, NUM_USERS)), ID_W'($urandom_range(1, NUM_MOVIES)),
                 IDX_W'($urandom_range(NUM_FACTORS, IDX_MAX)), pick_value());
        2: issue(ACT_W'($urandom_range(ACT_USER_FACTOR, ACT_MOVIE_BIAS)), bad_id(), bad_id(),
                 IDX_W'($urandom), pick_value());
        default: begin
          // A predict with an id out of range pairs it with a loaded id or a second bad id.
          case ($urandom_range(0, 2))
            0:       predict(bad_id(), m);
            1:       predict(u, bad_id());
            default: predict(bad_id(), bad_id());
          endcase
        end
      endcase
    end
  endtask

  initial begin
    logic [RATING_W-1:0] avg_setting;
    logic                bias_setting;
    rst          <= 1'b1;
    start        <= 1'b0;
    action       <= '0;
    user_id      <= '0;
    movie_id     <= '0;
    factor_index <= '0;
    load_value   <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_RATING_AVERAGE;
    cfg_data     <= '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Rows at the id extremes filled with the value extremes, plus an
    // all-zero pair for exact clamp-edge checks, then a few random rows.
    load_row(1'b1, 1, 1'b1, VAL_MAX);
    load_row(1'b1, NUM_USERS, 1'b1, VAL_MIN);
    load_row(1'b1, 2, 1'b1, '0);
    load_row(1'b0, 1, 1'b1, VAL_MAX);
    load_row(1'b0, NUM_MOVIES, 1'b1, VAL_MIN);
    load_row(1'b0, 2, 1'b1, '0);
    repeat (5) load_row(1'b1, $urandom_range(3, NUM_USERS - 1), 1'b0, '0);
    repeat (5) load_row(1'b0, $urandom_range(3, NUM_MOVIES - 1), 1'b0, '0);

    predict(ID_W'(1), ID_W'(1));
    predict(ID_W'(NUM_USERS), ID_W'(1));
    predict(ID_W'(1), ID_W'(NUM_MOVIES));
    predict(ID_W'(NUM_USERS), ID_W'(NUM_MOVIES));
    predict(ID_W'(2), ID_W'(2));
    // User bias chosen so that the total sits exactly on, or one step off,
    // each end of the clamp window.
    issue(ACT_USER_BIAS, ID_W'(2), any_id(), IDX_W'($urandom),
          VAL_W'(int'(RATING_MIN) - int'(RATING_AVERAGE_RESET)));
    predict(ID_W'(2), ID_W'(2));
    issue(ACT_USER_BIAS, ID_W'(2), any_id(), IDX_W'($urandom),
          VAL_W'(int'(RATING_MIN) - int'(RATING_AVERAGE_RESET) - 1));
    predict(ID_W'(2), ID_W'(2));
    issue(ACT_USER_BIAS, ID_W'(2), any_id(), IDX_W'($urandom),
          VAL_W'(int'(RATING_MAX) - int'(RATING_AVERAGE_RESET)));
    predict(ID_W'(2), ID_W'(2));
    issue(ACT_USER_BIAS, ID_W'(2), any_id(), IDX_W'($urandom),
          VAL_W'(int'(RATING_MAX) - int'(RATING_AVERAGE_RESET) - 1));
    predict(ID_W'(2), ID_W'(2));
    predict('0, ID_W'(2));
    predict(ID_W'(2), ID_W'(NUM_MOVIES + 1));
    predict(ID_W'(ID_MAX), '0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
      issue(ACT_W'(a), any_id(), any_id(), IDX_W'($urandom), VAL_W'($urandom));
    end
    // None of these loads may land, so the last predict must be unchanged.
    issue(ACT_USER_FACTOR, ID_W'(2), any_id(), IDX_W'(NUM_FACTORS), VAL_MAX);
    issue(ACT_MOVIE_FACTOR, any_id(), ID_W'(2), IDX_W'(IDX_MAX), VAL_MAX);
    issue(ACT_USER_BIAS, '0, any_id(), IDX_W'($urandom), VAL_MAX);
    issue(ACT_MOVIE_BIAS, any_id(), ID_W'(ID_MAX), IDX_W'($urandom), VAL_MAX);
    predict(ID_W'(2), ID_W'(2));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       avg_setting = RATING_AVERAGE_RESET;
        1:       avg_setting = '0;
        2:       avg_setting = RATING_MAX;
        default: avg_setting = RATING_W'($urandom_range(0, RATING_MAX));
      endcase
      bias_setting = (p != 3);
      write_reg(REG_RATING_AVERAGE, avg_setting);
      // Upper data bits are don't-care for the enable register.
      write_reg(REG_BIAS_ENABLE, (RATING_W'($urandom) << 1) | RATING_W'(bias_setting));
      cfg_valid <= 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 70 == 0) begin
          calm = ($urandom_range(0, 4) == 0);
        end
        random_item();
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
